// ----- src/rsp_pkg.sv -----
`timescale 1ns / 1ps

package rsp_pkg;

  // fixed point full-on brightness
  localparam int unsigned FullOn      = 4096;
  localparam int unsigned BlinkLast   = 14;
  localparam int unsigned DutyW       = 13;
  localparam int unsigned LevelW      = 15;
  localparam int unsigned StepW       = 12;
  localparam int unsigned DivW        = 6;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 12;

  // register reset values
  localparam logic [StepW-1:0] IdleStepRst    = 12'd41;
  localparam logic [StepW-1:0] RainbowStepRst = 12'd41;
  localparam logic [DivW-1:0]  ErrorDivRst    = 6'd5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IDLE_STEP    = 2'd0,
    CFG_RAINBOW_STEP = 2'd1,
    CFG_ERROR_DIVIDE = 2'd2
  } cfg_idx_t;

  // item operations
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  // display modes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ERROR   = 2'd1,
    MODE_RAINBOW = 2'd2
  } mode_t;

  // rainbow fade phases
  typedef enum logic [1:0] {
    FADE_RED   = 2'd0,
    FADE_GREEN = 2'd1,
    FADE_BLUE  = 2'd2
  } fade_t;

  typedef struct packed {
    logic [StepW-1:0] idle_step;
    logic [StepW-1:0] rainbow_step;
    logic [DivW-1:0]  error_divide;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] mode;
  } item_t;

  typedef struct packed {
    mode_t      cur_mode;
    logic [3:0] blink_phase;
  } status_t;

  // clamp a signed level to the 0..full duty range
  function automatic logic [DutyW-1:0] clamp_duty(input logic signed [LevelW-1:0] v);
    logic [DutyW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(LevelW'(FullOn))) begin
      res = DutyW'(FullOn);
    end else begin
      res = v[DutyW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- src/rgb_status_pattern_generator_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_operation, in_mode
// out_      output     out_valid / out_stall out_red_duty, out_green_duty, out_blue_duty
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; the result passes through the input register,
// which loads at the transfer, and then the colour register, which the pattern logic loads
// synchronous active-low reset restores all registers except the input payload to defaults, led off, idle mode
// out_stall backs up into in_stall in the same cycle; cfg_ready is always high

module rgb_status_pattern_generator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [1:0]                    in_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsp_pkg::DutyW-1:0]     out_red_duty,
  output logic [rsp_pkg::DutyW-1:0]     out_green_duty,
  output logic [rsp_pkg::DutyW-1:0]     out_blue_duty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rsp_pkg::CfgDataW-1:0]  cfg_data
);

  rsp_pkg::cfg_t    cfg;
  rsp_pkg::item_t   s1_item;
  rsp_pkg::status_t status;
  logic             s1_valid;
  logic             adv;

  assign cfg_ready = 1'b1;

  // configuration registers
  rsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  rsp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_mode      (in_mode),
    .in_stall     (in_stall),
    .adv          (adv),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  // pattern state and colour register
  rsp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .adv            (adv),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty),
    .out_blue_duty  (out_blue_duty),
    .status         (status)
  );

  // duties never exceed full on
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_red_duty <= rsp_pkg::DutyW'(rsp_pkg::FullOn) &&
    out_green_duty <= rsp_pkg::DutyW'(rsp_pkg::FullOn) &&
    out_blue_duty <= rsp_pkg::DutyW'(rsp_pkg::FullOn))
    else $error("duty above full on");

  // green only lights in rainbow mode
  a_green_rainbow: assert property (@(posedge clk) disable iff (!rst_n)
    status.cur_mode != rsp_pkg::MODE_RAINBOW |-> out_green_duty == '0)
    else $error("green lit outside rainbow mode");

  // blink phase stays below the period
  a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.blink_phase <= 4'(rsp_pkg::BlinkLast))
    else $error("blink phase out of range");

  // an item leaving the input register shows up as a result next cycle
  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && adv |=> out_valid)
    else $error("item lost between stages");

endmodule

// ----- src/rsp_cfg_regs.sv -----
`timescale 1ns / 1ps

module rsp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [rsp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rsp_pkg::CfgDataW-1:0]  cfg_data,
  output rsp_pkg::cfg_t                 cfg
);

  rsp_pkg::cfg_t cfg_r;
  rsp_pkg::cfg_t cfg_nxt;

  // register write decode, unknown indexes dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        rsp_pkg::CFG_IDLE_STEP:    cfg_nxt.idle_step    = cfg_data;
        rsp_pkg::CFG_RAINBOW_STEP: cfg_nxt.rainbow_step = cfg_data;
        rsp_pkg::CFG_ERROR_DIVIDE: cfg_nxt.error_divide = cfg_data[rsp_pkg::DivW-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_step    <= rsp_pkg::IdleStepRst;
      cfg_r.rainbow_step <= rsp_pkg::RainbowStepRst;
      cfg_r.error_divide <= rsp_pkg::ErrorDivRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/rsp_in_stage.sv -----
`timescale 1ns / 1ps

module rsp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  input  logic [1:0]     in_mode,
  output logic           in_stall,
  input  logic           adv,
  output logic           s1_valid,
  output rsp_pkg::item_t s1_item
);

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  rsp_pkg::item_t item_r;

  // stage holds while its item cannot move on
  assign in_stall     = s1_valid_r && !adv;
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.operation <= in_operation;
      item_r.mode      <= in_mode;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

endmodule

// ----- src/rsp_core.sv -----
`timescale 1ns / 1ps

module rsp_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rsp_pkg::cfg_t                cfg,
  input  logic                         s1_valid,
  input  rsp_pkg::item_t               s1_item,
  output logic                         adv,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [rsp_pkg::DutyW-1:0]    out_red_duty,
  output logic [rsp_pkg::DutyW-1:0]    out_green_duty,
  output logic [rsp_pkg::DutyW-1:0]    out_blue_duty,
  output rsp_pkg::status_t             status
);

  localparam int unsigned LW = rsp_pkg::LevelW;
  localparam int unsigned DW = rsp_pkg::DutyW;
  localparam logic signed [LW-1:0] FullLvl = LW'(rsp_pkg::FullOn);

  rsp_pkg::mode_t        mode_r,  mode_nxt;
  rsp_pkg::fade_t        fade_r,  fade_nxt;
  logic signed [LW-1:0]  level_r, level_nxt;
  logic                  rising_r, rising_nxt;
  logic [3:0]            blink_r, blink_nxt;
  logic [rsp_pkg::DivW-1:0] presc_r, presc_nxt;
  logic [DW-1:0]         red_r, red_nxt;
  logic [DW-1:0]         green_r, green_nxt;
  logic [DW-1:0]         blue_r, blue_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  take;
  logic signed [LW-1:0]  idle_step_s;
  logic signed [LW-1:0]  rain_step_s;
  logic signed [LW-1:0]  idle_sum;
  logic signed [LW-1:0]  rain_sum;
  logic signed [LW-1:0]  rain_inv;
  logic [rsp_pkg::DivW:0] presc_inc;
  logic [3:0]            blink_step;
  logic [2:0]            half;

  // result register free or being drained
  assign adv  = !out_valid_r || !out_stall;
  assign take = s1_valid && adv;

  // shared datapath terms
  always_comb begin
    idle_step_s = $signed({{(LW-rsp_pkg::StepW){1'b0}}, cfg.idle_step});
    rain_step_s = $signed({{(LW-rsp_pkg::StepW){1'b0}}, cfg.rainbow_step});
    idle_sum    = rising_r ? (level_r + idle_step_s) : (level_r - idle_step_s);
    rain_sum    = level_r + rain_step_s;
    rain_inv    = FullLvl - rain_sum;
    presc_inc   = {1'b0, presc_r} + 1'b1;
    blink_step  = (blink_r == 4'(rsp_pkg::BlinkLast)) ? 4'd0 : blink_r + 4'd1;
    half        = blink_step[3:1];
  end

  // next state for one item
  always_comb begin
    mode_nxt      = mode_r;
    fade_nxt      = fade_r;
    level_nxt     = level_r;
    rising_nxt    = rising_r;
    blink_nxt     = blink_r;
    presc_nxt     = presc_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid;
    end
    if (take) begin
      if (s1_item.operation == rsp_pkg::OP_SET) begin
        // a new mode blanks the led and restarts its pattern
        if (s1_item.mode <= 2'(rsp_pkg::MODE_RAINBOW) && s1_item.mode != 2'(mode_r)) begin
          mode_nxt  = rsp_pkg::mode_t'(s1_item.mode);
          red_nxt   = '0;
          green_nxt = '0;
          blue_nxt  = '0;
          presc_nxt = '0;
          case (rsp_pkg::mode_t'(s1_item.mode))
            rsp_pkg::MODE_IDLE: begin
              level_nxt  = '0;
              rising_nxt = 1'b1;
            end
            rsp_pkg::MODE_ERROR: begin
              blink_nxt = '0;
            end
            default: begin
              level_nxt = '0;
              fade_nxt  = rsp_pkg::FADE_RED;
            end
          endcase
        end
      end else begin
        case (mode_r)
          rsp_pkg::MODE_IDLE: begin
            // triangle breathing on blue
            level_nxt = idle_sum;
            if (rising_r && idle_sum > FullLvl) begin
              rising_nxt = 1'b0;
            end else if (!rising_r && idle_sum < 0) begin
              rising_nxt = 1'b1;
            end
            red_nxt   = '0;
            green_nxt = '0;
            blue_nxt  = rsp_pkg::clamp_duty(idle_sum);
          end
          rsp_pkg::MODE_ERROR: begin
            // blink sequence steps once per divide period
            if (presc_inc < {1'b0, cfg.error_divide}) begin
              presc_nxt = presc_inc[rsp_pkg::DivW-1:0];
            end else begin
              presc_nxt = '0;
              blink_nxt = blink_step;
              red_nxt   = '0;
              green_nxt = '0;
              blue_nxt  = '0;
              if (blink_step[0]) begin
                if (half >= 3'd1 && half <= 3'd3) begin
                  red_nxt = DW'(rsp_pkg::FullOn);
                end else if (half >= 3'd5) begin
                  blue_nxt = DW'(rsp_pkg::FullOn);
                end
              end
            end
          end
          default: begin
            // rainbow cross-fade
            case (fade_r)
              rsp_pkg::FADE_GREEN: begin
                red_nxt   = rsp_pkg::clamp_duty(rain_inv);
                green_nxt = rsp_pkg::clamp_duty(rain_sum);
                blue_nxt  = '0;
              end
              rsp_pkg::FADE_BLUE: begin
                red_nxt   = '0;
                green_nxt = rsp_pkg::clamp_duty(rain_inv);
                blue_nxt  = rsp_pkg::clamp_duty(rain_sum);
              end
              default: begin
                red_nxt   = rsp_pkg::clamp_duty(rain_sum);
                green_nxt = '0;
                blue_nxt  = rsp_pkg::clamp_duty(rain_inv);
              end
            endcase
            level_nxt = rain_sum;
            if (rain_sum > FullLvl) begin
              level_nxt = '0;
              case (fade_r)
                rsp_pkg::FADE_GREEN: fade_nxt = rsp_pkg::FADE_BLUE;
                rsp_pkg::FADE_BLUE:  fade_nxt = rsp_pkg::FADE_RED;
                default:             fade_nxt = rsp_pkg::FADE_GREEN;
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rsp_pkg::MODE_IDLE;
      fade_r      <= rsp_pkg::FADE_RED;
      level_r     <= '0;
      rising_r    <= 1'b1;
      blink_r     <= '0;
      presc_r     <= '0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      fade_r      <= fade_nxt;
      level_r     <= level_nxt;
      rising_r    <= rising_nxt;
      blink_r     <= blink_nxt;
      presc_r     <= presc_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_duty       = red_r;
  assign out_green_duty     = green_r;
  assign out_blue_duty      = blue_r;
  assign status.cur_mode    = mode_r;
  assign status.blink_phase = blink_r;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rsp_pkg::*;

  localparam int ClkHalf     = 6;
  localparam int StallHold   = 300;
  localparam int QuietLimit  = 2000;
  localparam int SettleWait  = 8;
  localparam int PhaseItems  = 250;
  localparam int PhaseCount  = 7;
  localparam int BlinkPeriod = BlinkLast + 1;
  localparam int MaxReports  = 40;
  localparam logic [1:0]         ModeUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare   = 2'd3;

  typedef struct packed {
    logic [DutyW-1:0] red;
    logic [DutyW-1:0] green;
    logic [DutyW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic       op;
    logic [1:0] mode;
    logic       typed;
    color_t     want;
  } row_t;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                in_operation = 1'b0;
  logic [1:0]          in_mode      = 2'd0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [DutyW-1:0]    out_red_duty;
  logic [DutyW-1:0]    out_green_duty;
  logic [DutyW-1:0]    out_blue_duty;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [CfgDataW-1:0] cfg_data     = '0;

  rgb_status_pattern_generator_top dut (.*);

  // predicted led state and register copy
  cfg_t                     regs;
  mode_t                    led_mode;
  logic signed [LevelW-1:0] led_level;
  logic                     led_rising;
  fade_t                    led_fade;
  logic [3:0]               led_blink;
  logic [DivW-1:0]          led_prescale;
  color_t                   led_color;

  color_t color_q[$];
  row_t   script[25];
  int     err_count = 0;
  int     quiet     = 0;
  bit     calm      = 1'b0;
  bit     hold_req  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // led pattern predictor

  function automatic logic [DutyW-1:0] duty_of(input int v);
    if (v < 0) return '0;
    if (v > int'(FullOn)) return DutyW'(FullOn);
    return DutyW'(v);
  endfunction

  function automatic void paint(input int r, input int g, input int b);
    led_color.red   = duty_of(r);
    led_color.green = duty_of(g);
    led_color.blue  = duty_of(b);
  endfunction

  function automatic void enter_mode(input mode_t m);
    led_mode     = m;
    led_prescale = '0;
    paint(0, 0, 0);
    case (m)
      MODE_IDLE: begin
        led_level  = '0;
        led_rising = 1'b1;
      end
      MODE_ERROR: begin
        led_blink = '0;
      end
      default: begin
        led_level = '0;
        led_fade  = FADE_RED;
      end
    endcase
  endfunction

  function automatic void led_power_on();
    regs.idle_step    = IdleStepRst;
    regs.rainbow_step = RainbowStepRst;
    regs.error_divide = ErrorDivRst;
    led_level    = '0;
    led_rising   = 1'b1;
    led_fade     = FADE_RED;
    led_blink    = '0;
    led_prescale = '0;
    enter_mode(MODE_IDLE);
  endfunction

  function automatic void led_advance(input logic op, input logic [1:0] m);
    int lv;
    int ph;
    bit change;
    if (op == OP_SET) begin
      // unknown mode and same mode leave everything alone
      if (m <= MODE_RAINBOW && m != led_mode) enter_mode(mode_t'(m));
    end else begin
      case (led_mode)
        MODE_IDLE: begin
          // triangle breathing on blue
          lv = int'(led_level);
          if (led_rising) begin
            lv += int'(regs.idle_step);
            if (lv > int'(FullOn)) led_rising = 1'b0;
          end else begin
            lv -= int'(regs.idle_step);
            if (lv < 0) led_rising = 1'b1;
          end
          led_level = LevelW'(lv);
          paint(0, 0, lv);
        end
        MODE_ERROR: begin
          // prescaled blink, color holds between steps
          if (int'(led_prescale) + 1 < int'(regs.error_divide)) begin
            led_prescale = led_prescale + 1'b1;
          end else begin
            led_prescale = '0;
            ph = (int'(led_blink) + 1) % BlinkPeriod;
            led_blink = 4'(ph);
            if (ph % 2 == 0) paint(0, 0, 0);
            else if (ph / 2 >= 1 && ph / 2 <= 3) paint(int'(FullOn), 0, 0);
            else if (ph / 2 >= 5 && ph / 2 <= 7) paint(0, 0, int'(FullOn));
            else paint(0, 0, 0);
          end
        end
        default: begin
          // rainbow cross-fade
          lv = int'(led_level) + int'(regs.rainbow_step);
          change = (lv > int'(FullOn));
          case (led_fade)
            FADE_GREEN: paint(int'(FullOn) - lv, lv, 0);
            FADE_BLUE:  paint(0, int'(FullOn) - lv, lv);
            default:    paint(lv, 0, int'(FullOn) - lv);
          endcase
          if (change) begin
            led_fade = (led_fade == FADE_GREEN) ? FADE_BLUE :
                       (led_fade == FADE_BLUE) ? FADE_RED : FADE_GREEN;
            lv = 0;
          end
          led_level = LevelW'(lv);
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic row_t row(input logic op, input logic [1:0] m, input logic typed,
                               input int r, input int g, input int b);
    row_t x;
    x.op         = op;
    x.mode       = m;
    x.typed      = typed;
    x.want.red   = DutyW'(r);
    x.want.green = DutyW'(g);
    x.want.blue  = DutyW'(b);
    return x;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // offer one item and hold it until the transfer happens
  task automatic send_item(input logic op, input logic [1:0] m, input logic typed,
                           input color_t want);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_mode      <= m;
    do @(posedge clk); while (!(in_valid && !in_stall));
    led_advance(op, m);
    color_q.push_back(typed ? want : led_color);
  endtask

  task automatic item_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid     <= 1'b0;
      in_operation <= 1'($urandom);
      in_mode      <= 2'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // sender pauses until every result is back, then lets the pipe go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_IDLE_STEP:    regs.idle_step    = data;
      CFG_RAINBOW_STEP: regs.rainbow_step = data;
      CFG_ERROR_DIVIDE: regs.error_divide = data[DivW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [DutyW-1:0] want,
                                      input logic [DutyW-1:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MaxReports)
        $display("%0t: %s duty mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls plus one long hold-off on request

  initial begin : stall_gen
    int len;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (StallHold) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(99) < 20) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result transfer with the oldest predicted color
  always @(posedge clk) begin : result_check
    color_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: result with none expected, actual %0d/%0d/%0d", $time,
                   out_red_duty, out_green_duty, out_blue_duty);
      end else begin
        want = color_q.pop_front();
        check_field("red", want.red, out_red_duty);
        check_field("green", want.green, out_green_duty);
        check_field("blue", want.blue, out_blue_duty);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin : main_seq
    logic [CfgDataW-1:0] step_a;
    logic [CfgDataW-1:0] step_b;
    logic [CfgDataW-1:0] divide;
    logic                op;
    color_t              none;

    none = '0;
    led_power_on();

    // directed rows, error pattern stepping on every tick
    script[0]  = row(OP_TICK, MODE_IDLE,    1, 0, 0, 41);
    script[1]  = row(OP_SET,  ModeUnused,   1, 0, 0, 41);
    script[2]  = row(OP_SET,  MODE_IDLE,    1, 0, 0, 41);
    script[3]  = row(OP_SET,  MODE_ERROR,   1, 0, 0, 0);
    script[4]  = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[5]  = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[6]  = row(OP_TICK, MODE_IDLE,    1, FullOn, 0, 0);
    script[7]  = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[8]  = row(OP_TICK, MODE_IDLE,    1, FullOn, 0, 0);
    script[9]  = row(OP_SET,  MODE_ERROR,   1, FullOn, 0, 0);
    script[10] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[11] = row(OP_TICK, MODE_IDLE,    1, FullOn, 0, 0);
    script[12] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[13] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[14] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[15] = row(OP_TICK, MODE_IDLE,    1, 0, 0, FullOn);
    script[16] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[17] = row(OP_TICK, MODE_IDLE,    1, 0, 0, FullOn);
    script[18] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[19] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 0);
    script[20] = row(OP_SET,  MODE_RAINBOW, 1, 0, 0, 0);
    script[21] = row(OP_TICK, MODE_IDLE,    0, 0, 0, 0);
    script[22] = row(OP_TICK, MODE_IDLE,    0, 0, 0, 0);
    script[23] = row(OP_SET,  MODE_IDLE,    1, 0, 0, 0);
    script[24] = row(OP_TICK, MODE_IDLE,    1, 0, 0, 41);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(CFG_ERROR_DIVIDE, '0);
    for (int i = 0; i < $size(script); i++) begin
      send_item(script[i].op, script[i].mode, script[i].typed, script[i].want);
      item_gap();
    end
    settle();

    // random phases over several register settings
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin step_a = '1;     step_b = '1;     divide = 12'd63; end
        1: begin step_a = 12'd1;  step_b = 12'd1;  divide = 12'd1;  end
        2: begin step_a = '0;     step_b = '0;     divide = '0;     end
        3: begin step_a = 12'd41; step_b = 12'd41; divide = 12'd5;  end
        default: begin
          step_a = CfgDataW'($urandom);
          step_b = CfgDataW'($urandom);
          divide = CfgDataW'($urandom);
        end
      endcase
      cfg_write(CFG_IDLE_STEP, step_a);
      cfg_write(CFG_RAINBOW_STEP, step_b);
      cfg_write(CFG_ERROR_DIVIDE, divide);
      if (p == 3) cfg_write(CfgSpare, CfgDataW'($urandom));

      // receiver holds off while the sender keeps offering
      if (p == 1) hold_req = 1'b1;

      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 50 == 0) calm = ($urandom_range(3) == 0);
        op = ($urandom_range(99) < 10) ? OP_SET : OP_TICK;
        send_item(op, 2'($urandom_range(3)), 1'b0, none);
        item_gap();
      end
      calm = 1'b0;
      settle();
    end

    if (err_count == 0 && color_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
